// ----- hdl/cfwdf_pkg.sv -----
package cfwdf_pkg;

  // Field width limit and value width
  localparam int MAX_DIGITS = 14;
  localparam int VALUE_W    = 48;

  // A 48-bit magnitude has at most 15 decimal digits
  localparam int MAG_DIGITS = 15;
  localparam int NUM_CELLS  = (MAX_DIGITS > MAG_DIGITS) ? MAX_DIGITS : MAG_DIGITS;

  // Counter width that holds NUM_CELLS + 1
  localparam int CNT_W   = $clog2(NUM_CELLS + 2);
  localparam int SHIFT_W = $clog2(VALUE_W);

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // Operation applied to every digit cell in the row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

endpackage

// ----- hdl/cfwdf_cell.sv -----
module cfwdf_cell (
  input  logic                clk,
  input  cfwdf_pkg::cell_op_t op,
  input  logic                carry_in,   // bit shifted up from the lower cell
  input  logic [3:0]          digit_in,   // digit of the lower cell
  output logic                carry_out,  // bit shifted up into the upper cell
  output logic [3:0]          digit
);

  logic [3:0] adj;

  // Add-3 correction before each binary shift
  always_comb begin
    adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adj[3];
  end

  always_ff @(posedge clk) begin
    case (op)
      cfwdf_pkg::CELL_CLR:    digit <= 4'd0;
      cfwdf_pkg::CELL_DABBLE: digit <= {adj[2:0], carry_in};
      cfwdf_pkg::CELL_SHIFT:  digit <= digit_in;
      default:                digit <= digit;
    endcase
  end

endmodule

// ----- hdl/cfwdf_chain.sv -----
module cfwdf_chain (
  input  logic                clk,
  input  cfwdf_pkg::cell_op_t op,
  input  logic                serial_in,  // next magnitude bit, MSB first
  output logic [3:0]          top_digit   // most significant digit cell
);

  logic                carry [cfwdf_pkg::NUM_CELLS:0];
  logic [3:0]          digits [cfwdf_pkg::NUM_CELLS-1:0];
  logic [3:0]          shift_in [cfwdf_pkg::NUM_CELLS-1:0];

  assign carry[0] = serial_in;

  // Row of BCD cells, cell 0 is the least significant digit
  for (genvar i = 0; i < cfwdf_pkg::NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      assign shift_in[i] = 4'd0;
    end else begin : g_upper
      assign shift_in[i] = digits[i-1];
    end

    cfwdf_cell u_cell (
      .clk       (clk),
      .op        (op),
      .carry_in  (carry[i]),
      .digit_in  (shift_in[i]),
      .carry_out (carry[i+1]),
      .digit     (digits[i])
    );
  end

  assign top_digit = digits[cfwdf_pkg::NUM_CELLS-1];

endmodule

// ----- hdl/clamped_fixed_width_decimal_formatter_unit.sv -----
// Clamped fixed-width decimal formatter.
// Slave stream s_*: one item holds a command word, a digit count, an
// always-signed flag, lower/upper limits and a signed 48-bit value.
// Master stream m_*: one ASCII byte per item: four command bytes, an
// optional sign, zero-padded digits, then ';' with m_tlast set.
// The value is clamped on accept. A row of 15 BCD cells converts the
// magnitude with one shift-and-adjust step per cycle, then folds the
// digits above the field into the leading character, one digit per
// cycle.
// Command and sign bytes go out while the conversion runs.
// Items are handled one at a time: s_tready rises again once the
// closing ';' is loaded into the output register.
// A stall on m_tready holds the output byte and pauses the emitter; the
// conversion keeps running. Reset clears all control state and drops
// m_tvalid; no byte is lost or repeated across stalls.
module clamped_fixed_width_decimal_formatter_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] command_word, [35:32] digit_count, [36] always_signed,
  // [84:37] lower_limit, [132:85] upper_limit, [180:133] value, rest zero
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] out_char
  output logic [7:0]   m_tdata,
  output logic         m_tlast
);

  localparam int VW = cfwdf_pkg::VALUE_W;
  localparam int CW = cfwdf_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_SIGN, S_LEAD, S_DIGIT, S_SEMI
  } emit_state_t;

  typedef enum logic [2:0] {
    E_IDLE, E_MAG, E_CONV, E_FOLD, E_DONE
  } eng_state_t;

  emit_state_t emit_state;
  eng_state_t  eng_state;

  // Input fields
  logic [31:0]          in_cmd;
  logic [3:0]           in_count;
  logic                 in_always;
  logic signed [VW-1:0] in_lo;
  logic signed [VW-1:0] in_hi;
  logic signed [VW-1:0] in_val;

  assign in_cmd    = s_tdata[31:0];
  assign in_count  = s_tdata[35:32];
  assign in_always = s_tdata[36];
  assign in_lo     = s_tdata[84:37];
  assign in_hi     = s_tdata[132:85];
  assign in_val    = s_tdata[180:133];

  // Item registers
  logic [31:0]            cmd_reg;
  logic [VW-1:0]          clamped;
  logic [VW-1:0]          mag;
  logic                   neg;
  logic                   has_sign;
  logic [CW-1:0]          n_dig;
  logic [CW-1:0]          dig_left;
  logic [CW-1:0]          fold_cnt;
  logic [1:0]             cmd_cnt;
  logic [cfwdf_pkg::SHIFT_W-1:0] conv_cnt;
  logic [7:0]             acc;

  // Accept-time decode
  logic signed [VW-1:0] clamp_val;
  logic                 clamp_neg;
  logic                 sign_next;
  logic [CW-1:0]        pos_lim;
  logic [CW-1:0]        pos_adj;
  logic [CW-1:0]        n_next;
  logic                 accept;

  assign s_tready = (emit_state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (in_val > in_hi)      clamp_val = in_hi;
    else if (in_val < in_lo) clamp_val = in_lo;
    else                     clamp_val = in_val;
    clamp_neg = clamp_val[VW-1];
    sign_next = clamp_neg || in_always;
    pos_lim   = ({{(CW-4){1'b0}}, in_count} > CW'(cfwdf_pkg::MAX_DIGITS)) ?
                CW'(cfwdf_pkg::MAX_DIGITS) : {{(CW-4){1'b0}}, in_count};
    pos_adj   = (sign_next && (pos_lim != '0)) ? pos_lim - CW'(1) : pos_lim;
    n_next    = (pos_adj == '0) ? CW'(1) : pos_adj;
  end

  // Digit row
  cfwdf_pkg::cell_op_t cell_op;
  logic [3:0]          top_digit;

  cfwdf_chain u_chain (
    .clk       (clk),
    .op        (cell_op),
    .serial_in (mag[VW-1]),
    .top_digit (top_digit)
  );

  // Emitter byte selection
  logic       slot_free;
  logic       emit_load;
  logic [7:0] emit_byte;
  logic       emit_last;

  always_comb begin
    slot_free = !m_tvalid || m_tready;
    emit_load = 1'b0;
    emit_byte = cfwdf_pkg::CHAR_SEMI;
    emit_last = 1'b0;
    unique case (emit_state)
      S_IDLE: ;
      S_CMD: begin
        emit_load = slot_free;
        emit_byte = cmd_reg[31:24];
      end
      S_SIGN: begin
        emit_load = slot_free;
        emit_byte = neg ? cfwdf_pkg::CHAR_MINUS : cfwdf_pkg::CHAR_PLUS;
      end
      S_LEAD: begin
        emit_load = slot_free && (eng_state == E_DONE);
        emit_byte = acc + cfwdf_pkg::CHAR_ZERO;
      end
      S_DIGIT: begin
        emit_load = slot_free;
        emit_byte = {4'd0, top_digit} + cfwdf_pkg::CHAR_ZERO;
      end
      S_SEMI: begin
        emit_load = slot_free;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Row operation
  always_comb begin
    unique case (eng_state)
      E_MAG:   cell_op = cfwdf_pkg::CELL_CLR;
      E_CONV:  cell_op = cfwdf_pkg::CELL_DABBLE;
      E_FOLD:  cell_op = cfwdf_pkg::CELL_SHIFT;
      E_DONE:  cell_op = (emit_state == S_DIGIT && emit_load) ?
                         cfwdf_pkg::CELL_SHIFT : cfwdf_pkg::CELL_HOLD;
      default: cell_op = cfwdf_pkg::CELL_HOLD;
    endcase
  end

  // Conversion engine
  always_ff @(posedge clk) begin
    if (rst) begin
      eng_state <= E_IDLE;
    end else begin
      unique case (eng_state) inside
        E_IDLE, E_DONE: begin
          if (accept) eng_state <= E_MAG;
        end
        E_MAG: begin
          mag       <= clamped[VW-1] ? VW'(-clamped) : clamped;
          conv_cnt  <= '0;
          eng_state <= E_CONV;
        end
        E_CONV: begin
          mag      <= {mag[VW-2:0], 1'b0};
          conv_cnt <= conv_cnt + 1'b1;
          if (conv_cnt == cfwdf_pkg::SHIFT_W'(VW - 1)) begin
            fold_cnt  <= CW'(cfwdf_pkg::NUM_CELLS + 1) - n_dig;
            acc       <= 8'd0;
            eng_state <= E_FOLD;
          end
        end
        E_FOLD: begin
          // acc = acc * 10 + digit, kept to 8 bits
          acc      <= {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + {4'd0, top_digit};
          fold_cnt <= fold_cnt - 1'b1;
          if (fold_cnt == CW'(1)) eng_state <= E_DONE;
        end
        default: eng_state <= E_IDLE;
      endcase
    end
  end

  // Item capture and byte emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_state <= S_IDLE;
      m_tvalid   <= 1'b0;
    end else begin
      if (emit_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= emit_byte;
        m_tlast  <= emit_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (emit_state)
        S_IDLE: begin
          if (accept) begin
            cmd_reg    <= in_cmd;
            clamped    <= clamp_val;
            neg        <= clamp_neg;
            has_sign   <= sign_next;
            n_dig      <= n_next;
            cmd_cnt    <= 2'd0;
            emit_state <= S_CMD;
          end
        end
        S_CMD: begin
          if (emit_load) begin
            cmd_reg <= {cmd_reg[23:0], 8'd0};
            cmd_cnt <= cmd_cnt + 2'd1;
            if (cmd_cnt == 2'd3) emit_state <= has_sign ? S_SIGN : S_LEAD;
          end
        end
        S_SIGN: begin
          if (emit_load) emit_state <= S_LEAD;
        end
        S_LEAD: begin
          if (emit_load) begin
            dig_left   <= n_dig - CW'(1);
            emit_state <= (n_dig == CW'(1)) ? S_SEMI : S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (emit_load) begin
            dig_left <= dig_left - CW'(1);
            if (dig_left == CW'(1)) emit_state <= S_SEMI;
          end
        end
        S_SEMI: begin
          if (emit_load) emit_state <= S_IDLE;
        end
        default: emit_state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_clamped_fixed_width_decimal_formatter_unit.sv -----
module tb_clamped_fixed_width_decimal_formatter_unit;

  localparam longint MIN48  = -64'sd140737488355328;
  localparam longint MAX48  = 64'sd140737488355327;
  localparam longint MAXDEC = 64'sd99999999999999;
  localparam int     RANDOM_ITEMS = 250;

  // One output byte with its end-of-message mark
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // [31:0] command_word, [35:32] digit_count, [36] always_signed,
  // [84:37] lower_limit, [132:85] upper_limit, [180:133] value, rest zero
  logic [183:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // [7:0] out_char
  logic [7:0]   m_tdata;
  logic         m_tlast;

  out_byte_t    pending_chars[$];
  out_byte_t    want;
  logic [183:0] dir_items[$];
  string        dir_text[$];
  int           mismatches = 0;
  bit           idle_on;
  bit           hold_req;

  clamped_fixed_width_decimal_formatter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void expect_char(input logic [7:0] ch, input logic last);
    pending_chars.push_back({ch, last});
  endfunction

  function automatic logic [183:0] pack_item(input logic [31:0] cmd, input logic [3:0] cnt,
                                             input logic alw, input longint lo,
                                             input longint hi, input longint v);
    logic [47:0] lo48, hi48, v48;
    lo48 = lo[47:0];
    hi48 = hi[47:0];
    v48  = v[47:0];
    return {3'b000, v48, hi48, lo48, alw, cnt, cmd};
  endfunction

  // Command bytes, clamp, sign, zero-padded decimal digits and ';' of one item
  function automatic void format_message(input logic [183:0] d);
    logic [31:0]     cmd;
    int unsigned     pos;
    int              i;
    longint          lo, hi, v;
    longint unsigned mag, dv, q;
    cmd = d[31:0];
    pos = d[35:32];
    lo  = {{16{d[84]}}, d[84:37]};
    hi  = {{16{d[132]}}, d[132:85]};
    v   = {{16{d[180]}}, d[180:133]};
    if (pos > cfwdf_pkg::MAX_DIGITS) pos = cfwdf_pkg::MAX_DIGITS;
    // upper limit is tested first, so it wins for values above it when the limits cross
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    for (i = 0; i < 4; i++) expect_char(cmd[31 - 8 * i -: 8], 1'b0);
    if (v < 0) begin
      expect_char(cfwdf_pkg::CHAR_MINUS, 1'b0);
      mag = -v;
      if (pos > 0) pos--;
    end else begin
      mag = v;
      if (d[36]) begin
        expect_char(cfwdf_pkg::CHAR_PLUS, 1'b0);
        if (pos > 0) pos--;
      end
    end
    dv = 1;
    for (i = 1; i < pos; i++) dv *= 10;
    // leading quotient may exceed 9; it is added to '0' and truncated
    while (dv > 1) begin
      q = mag / dv;
      expect_char(8'(q + cfwdf_pkg::CHAR_ZERO), 1'b0);
      mag -= q * dv;
      dv /= 10;
    end
    expect_char(8'(mag + cfwdf_pkg::CHAR_ZERO), 1'b0);
    expect_char(cfwdf_pkg::CHAR_SEMI, 1'b1);
  endfunction

  task automatic add_row(input logic [31:0] cmd, input logic [3:0] cnt, input logic alw,
                         input longint lo, input longint hi, input longint v,
                         input string txt);
    dir_items.push_back(pack_item(cmd, cnt, alw, lo, hi, v));
    dir_text.push_back(txt);
  endtask

  function automatic longint rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return {{16{r[47]}}, r[47:0]};
  endfunction

  // Signed decimal of random length, up to fourteen digits
  function automatic longint rand_dec();
    longint unsigned lim, m;
    lim = 1;
    repeat ($urandom_range(1, 14)) lim *= 10;
    m = {$urandom, $urandom};
    m = m % lim;
    return $urandom_range(0, 1) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(0, 5))
      0: return MIN48;
      1: return MAX48;
      2: return MAXDEC;
      3: return -MAXDEC;
      4: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [183:0] rand_item();
    longint a, b, lo, hi, v;
    a = rand_dec();
    b = rand_dec();
    v = rand_dec();
    case ($urandom_range(0, 9))
      6, 7: begin
        a = rand48();
        b = rand48();
        v = rand48();
      end
      9: begin
        a = pick_extreme();
        b = pick_extreme();
        v = pick_extreme();
      end
      default: ;
    endcase
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    // crossed limits now and then
    if ($urandom_range(0, 9) == 8) begin
      lo = hi;
      hi = (a < b) ? a : b;
    end
    case ($urandom_range(0, 7))
      0: v = lo;
      1: v = hi;
      default: ;
    endcase
    return pack_item($urandom, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     lo, hi, v);
  endfunction

  // Offer one item, record its expected bytes on accept
  task automatic send_item(input logic [183:0] d, input string txt);
    int n;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    if (txt.len() == 0) begin
      format_message(d);
    end else begin
      n = txt.len();
      for (int i = 0; i < n; i++) expect_char(txt[i], i == n - 1);
    end
  endtask

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Output checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected byte: char %h last %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (want != {m_tdata, m_tlast}) begin
          if (mismatches < 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.last, m_tdata, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int drain;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;

    // directed rows; blank text means the predictor supplies the bytes
    add_row("ZZFA", 5, 1, -99999, 99999, 5, "ZZFA+0005;");
    add_row("ZZFA", 5, 0, -99999, 99999, -42, "ZZFA-0042;");
    add_row("ZZAG", 3, 0, -999, 999, 0, "ZZAG000;");
    add_row("ZZAG", 3, 1, -999, 999, 0, "ZZAG+00;");
    add_row("ABCD", 0, 0, 0, 9, 7, "ABCD7;");
    add_row("ABCD", 0, 1, -9, 9, -3, "ABCD-3;");
    add_row("ABCD", 1, 1, 0, 9, 3, "ABCD+3;");
    add_row("ABCD", 1, 0, -9, 9, -9, "ABCD-9;");
    add_row("ZZFB", 14, 0, 0, MAXDEC, MAXDEC, "ZZFB99999999999999;");
    add_row("ZZFB", 15, 0, 0, MAXDEC, MAXDEC, "ZZFB99999999999999;");
    add_row("ZZFB", 14, 1, -MAXDEC, MAXDEC, -MAXDEC, "");
    add_row("ZZFB", 15, 1, -MAXDEC, 0, 0, "ZZFB+0000000000000;");
    add_row("ZZLM", 4, 0, 0, 100, 500, "ZZLM0100;");
    add_row("ZZLM", 4, 0, -100, 100, -500, "ZZLM-100;");
    add_row("ZZLM", 5, 0, 100, -100, 0, "ZZLM-0100;");
    add_row("ZZLM", 5, 0, 100, -100, -200, "ZZLM00100;");
    add_row("ZZLM", 4, 1, -50, 50, 50, "ZZLM+050;");
    add_row("ZZLM", 4, 1, -50, 50, -50, "ZZLM-050;");
    add_row("ZZOV", 2, 0, 0, 999, 123, "");
    add_row("ZZOV", 3, 1, -999999, 0, -98765, "");
    add_row(32'h00000000, 6, 0, MIN48, MAX48, MIN48, "");
    add_row(32'hFFFFFFFF, 14, 1, MIN48, MAX48, MAX48, "");
    add_row(32'h80017F7E, 9, 0, MIN48, MAX48, -1, "");
    add_row("ZZAG", 8, 0, 0, 0, 0, "ZZAG00000000;");

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_items[i]) send_item(dir_items[i], dir_text[i]);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // long receiver hold-off while items keep coming
      if (k == 80) hold_req = 1'b1;
      // sender waits for the block to drain completely
      if (k == 160) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
      end
      if (k == RANDOM_ITEMS - 40) idle_on = 1'b0;
      send_item(rand_item(), "");
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    drain = 0;
    while (pending_chars.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    if (pending_chars.size() != 0)
      $display("%0d expected bytes never arrived", pending_chars.size());

    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("tb_clamped_fixed_width_decimal_formatter_unit passed");
    end else begin
      $display("tb_clamped_fixed_width_decimal_formatter_unit failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_clamped_fixed_width_decimal_formatter_unit failed");
    $finish;
  end

endmodule
